### src/wavetable_oscillator_lerp_core_defines.svh
// Assertion helpers for the oscillator RTL; wtosc_table.sv uses them.
// Each helper names the assertion, samples on the rising clock edge and is
// switched off while the synchronous reset is high.
`ifndef WAVETABLE_OSCILLATOR_LERP_CORE_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_LERP_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTOSC_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WTOSC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/wtosc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wtosc_pkg;

   localparam int TABLE_BITS_DEFAULT = 10;
   localparam int FRAC_BITS_DEFAULT  = 16;

   localparam int FREQ_W   = 32;
   localparam int SCALE_W  = 32;
   localparam int ADDR_W   = 10;
   localparam int SAMPLE_W = 16;

   // Fraction bits of freq (Q16.16) times step_scale (Q8.24).
   localparam int PROD_FRAC_BITS = 40;

   localparam logic [SCALE_W-1:0] STEP_SCALE_RESET = 32'd357914;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_WRITE  = 1'b1
   } kind_type;

endpackage

`default_nettype wire

### src/wtosc_step.sv
`timescale 1ns / 1ps
`default_nettype none

module wtosc_step #(
   parameter int TABLE_BITS = wtosc_pkg::TABLE_BITS_DEFAULT,
   parameter int FRAC_BITS  = wtosc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [wtosc_pkg::SCALE_W-1:0]         csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic signed [wtosc_pkg::FREQ_W-1:0]   req_freq,
   input  logic [wtosc_pkg::ADDR_W-1:0]          req_table_addr,
   input  logic signed [wtosc_pkg::SAMPLE_W-1:0] req_table_value,
   output logic                                  dn_valid,
   input  logic                                  dn_stall,
   output wtosc_pkg::kind_type                   dn_kind,
   output logic [wtosc_pkg::ADDR_W-1:0]          dn_addr,
   output logic signed [wtosc_pkg::SAMPLE_W-1:0] dn_value,
   output logic [TABLE_BITS+FRAC_BITS-1:0]       dn_inc
);
   import wtosc_pkg::*;

   localparam int PHASE_BITS = TABLE_BITS + FRAC_BITS;
   localparam int INC_SHIFT  = PROD_FRAC_BITS - FRAC_BITS;
   localparam int PROD_W     = FREQ_W + SCALE_W + 1;

   logic [SCALE_W-1:0]         scale_ff;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   kind_type                   s1_kind_ff;
   logic signed [FREQ_W-1:0]   s1_freq_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic signed [SAMPLE_W-1:0] s1_value_ff;

   logic                       s2_valid_ff;
   logic                       s2_valid_in;
   kind_type                   s2_kind_ff;
   logic [ADDR_W-1:0]          s2_addr_ff;
   logic signed [SAMPLE_W-1:0] s2_value_ff;
   logic [PHASE_BITS-1:0]      s2_inc_ff;
   logic [PHASE_BITS-1:0]      s2_inc_in;

   logic                       s1_free;
   logic                       s2_free;
   logic signed [SCALE_W:0]    scale_signed;
   logic signed [PROD_W-1:0]   product;

   assign s2_free   = !s2_valid_ff || !dn_stall;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   assign s1_valid_in = s1_free ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   // Signed Q25.40 product; the arithmetic shift to the phase format is a
   // plain bit slice, and the slice width wraps it modulo the phase range.
   assign scale_signed = {1'b0, scale_ff};
   assign product      = PROD_W'(s1_freq_ff) * PROD_W'(scale_signed);
   assign s2_inc_in    = product[INC_SHIFT +: PHASE_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= STEP_SCALE_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            scale_ff <= csr_write_data;
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_free) begin
         s1_kind_ff  <= kind_type'(req_kind);
         s1_freq_ff  <= req_freq;
         s1_addr_ff  <= req_table_addr;
         s1_value_ff <= req_table_value;
      end
      if (s1_valid_ff && s2_free) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_value_ff <= s1_value_ff;
         s2_inc_ff   <= s2_inc_in;
      end
   end

   assign dn_valid = s2_valid_ff;
   assign dn_kind  = s2_kind_ff;
   assign dn_addr  = s2_addr_ff;
   assign dn_value = s2_value_ff;
   assign dn_inc   = s2_inc_ff;

endmodule

`default_nettype wire

### src/wtosc_table.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wavetable_oscillator_lerp_core_defines.svh"

module wtosc_table #(
   parameter int TABLE_BITS = wtosc_pkg::TABLE_BITS_DEFAULT,
   parameter int FRAC_BITS  = wtosc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_stall,
   input  wtosc_pkg::kind_type                   up_kind,
   input  logic [wtosc_pkg::ADDR_W-1:0]          up_addr,
   input  logic signed [wtosc_pkg::SAMPLE_W-1:0] up_value,
   input  logic [TABLE_BITS+FRAC_BITS-1:0]       up_inc,
   output logic                                  dn_valid,
   input  logic                                  dn_stall,
   output logic signed [wtosc_pkg::SAMPLE_W-1:0] dn_a,
   output logic signed [wtosc_pkg::SAMPLE_W-1:0] dn_b,
   output logic [FRAC_BITS-1:0]                  dn_frac
);
   import wtosc_pkg::*;

   localparam int PHASE_BITS = TABLE_BITS + FRAC_BITS;
   localparam int TABLE_LEN  = 1 << TABLE_BITS;
   localparam int ADDR_EXT_W = (TABLE_BITS > ADDR_W) ? TABLE_BITS : ADDR_W;

   logic [SAMPLE_W-1:0]   wave_mem [TABLE_LEN];

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic                  tap_valid_ff;
   logic                  tap_valid_in;
   logic [SAMPLE_W-1:0]   rd_a_ff;
   logic [SAMPLE_W-1:0]   rd_b_ff;
   logic [FRAC_BITS-1:0]  frac_ff;

   logic                  free;
   logic                  fire;
   logic                  fire_sample;
   logic                  fire_write;
   logic [ADDR_EXT_W-1:0] addr_ext;
   logic [TABLE_BITS-1:0] wr_addr;
   logic [TABLE_BITS-1:0] rd_idx;
   logic [TABLE_BITS-1:0] rd_nxt;

   assign free        = !tap_valid_ff || !dn_stall;
   assign fire        = up_valid && free;
   assign fire_sample = fire && (up_kind == KIND_SAMPLE);
   assign fire_write  = fire && (up_kind == KIND_WRITE);
   assign up_stall    = !free;

   // Addresses beyond the table wrap onto its low bits.
   assign addr_ext = ADDR_EXT_W'(up_addr);
   assign wr_addr  = addr_ext[TABLE_BITS-1:0];

   // The neighbor entry wraps to zero after the last one.
   assign rd_idx = phase_ff[PHASE_BITS-1 -: TABLE_BITS];
   assign rd_nxt = rd_idx + TABLE_BITS'(1);

   assign phase_in     = fire_sample ? (phase_ff + up_inc) : phase_ff;
   assign tap_valid_in = free ? fire_sample : tap_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         tap_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tap_valid_ff <= tap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_write) begin
         wave_mem[wr_addr] <= up_value;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_sample) begin
         rd_a_ff <= wave_mem[rd_idx];
         rd_b_ff <= wave_mem[rd_nxt];
         frac_ff <= phase_ff[FRAC_BITS-1:0];
      end
   end

   assign dn_valid = tap_valid_ff;
   assign dn_a     = signed'(rd_a_ff);
   assign dn_b     = signed'(rd_b_ff);
   assign dn_frac  = frac_ff;

   `WTOSC_ASSERT_NEXT(a_write_holds_phase, clock, reset, fire_write, $stable(phase_ff), "a table write moved the phase")
   `WTOSC_ASSERT_NEXT(a_sample_loads_taps, clock, reset, fire_sample, tap_valid_ff, "a sample transaction left no taps")
   `WTOSC_ASSERT_NEXT(a_held_taps_stable, clock, reset, (tap_valid_ff && dn_stall), (tap_valid_ff && $stable(frac_ff) && $stable(phase_ff)), "held taps or phase changed under stall")

endmodule

`default_nettype wire

### src/wtosc_lerp.sv
`timescale 1ns / 1ps
`default_nettype none

module wtosc_lerp #(
   parameter int FRAC_BITS = wtosc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_stall,
   input  logic signed [wtosc_pkg::SAMPLE_W-1:0] up_a,
   input  logic signed [wtosc_pkg::SAMPLE_W-1:0] up_b,
   input  logic [FRAC_BITS-1:0]                  up_frac,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [wtosc_pkg::SAMPLE_W-1:0] rsp_sample
);
   import wtosc_pkg::*;

   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int ACC_W  = DIFF_W + FRAC_BITS + 1;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

   logic                       m_valid_ff;
   logic                       m_valid_in;
   logic signed [ACC_W-1:0]    m_prod_ff;
   logic signed [SAMPLE_W-1:0] m_a_ff;

   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff;
   logic signed [SAMPLE_W-1:0] out_sample_in;

   logic                       m_free;
   logic                       out_free;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [FRAC_BITS:0]  frac_signed;
   logic signed [ACC_W-1:0]    product;
   logic signed [ACC_W-1:0]    acc;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign m_free   = !m_valid_ff || out_free;
   assign up_stall = !m_free;

   assign m_valid_in   = m_free ? up_valid : m_valid_ff;
   assign out_valid_in = out_free ? m_valid_ff : out_valid_ff;

   // (b - a) * f, registered before the final sum.
   assign diff        = DIFF_W'(up_b) - DIFF_W'(up_a);
   assign frac_signed = {1'b0, up_frac};
   assign product     = ACC_W'(diff) * ACC_W'(frac_signed);

   // a * 2^F + (b - a) * f + half, then floor by dropping the fraction bits.
   // The result lies between a and b, so the slice cannot overflow.
   assign acc           = (ACC_W'(m_a_ff) <<< FRAC_BITS) + m_prod_ff + ROUND_HALF;
   assign out_sample_in = acc[FRAC_BITS +: SAMPLE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && m_free) begin
         m_prod_ff <= product;
         m_a_ff    <= up_a;
      end
      if (m_valid_ff && out_free) begin
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;

endmodule

`default_nettype wire

### src/wavetable_oscillator_lerp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle while the output is not stalled; the phase loop is a single registered add.
// Table writes give no result and take one slot of the same pipeline.
// Reset (synchronous, active high) clears phase, pipeline valids and step_scale
// to 357914; the wave table is not cleared and must be written before use.
module wavetable_oscillator_lerp_core #(
   parameter int TABLE_BITS = wtosc_pkg::TABLE_BITS_DEFAULT,
   parameter int FRAC_BITS  = wtosc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [wtosc_pkg::SCALE_W-1:0]         csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic signed [wtosc_pkg::FREQ_W-1:0]   req_freq,
   input  logic [wtosc_pkg::ADDR_W-1:0]          req_table_addr,
   input  logic signed [wtosc_pkg::SAMPLE_W-1:0] req_table_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [wtosc_pkg::SAMPLE_W-1:0] rsp_sample
);
   import wtosc_pkg::*;

   localparam int PHASE_BITS = TABLE_BITS + FRAC_BITS;

   // The pipeline has five register levels:
   //   1. input register holding the accepted transaction,
   //   2. phase increment (freq * step_scale, sliced to the phase format),
   //   3. table taps and phase fraction, with the phase accumulator updated
   //      in the same step so the next sample sees the advanced phase,
   //   4. the (b - a) * f product,
   //   5. the output register with the rounded sample.
   // Every stage carries a valid bit and moves whenever the stage after it is
   // empty or is being emptied, so the input can keep flowing into empty stages
   // while a finished result waits on a stalled output.

   logic                       step_valid;
   logic                       step_stall;
   kind_type                   step_kind;
   logic [ADDR_W-1:0]          step_addr;
   logic signed [SAMPLE_W-1:0] step_value;
   logic [PHASE_BITS-1:0]      step_inc;

   logic                       tap_valid;
   logic                       tap_stall;
   logic signed [SAMPLE_W-1:0] tap_a;
   logic signed [SAMPLE_W-1:0] tap_b;
   logic [FRAC_BITS-1:0]       tap_frac;

   // Stages 1 and 2, plus the step_scale register.
   wtosc_step #(
      .TABLE_BITS (TABLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_step (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_freq         (req_freq),
      .req_table_addr   (req_table_addr),
      .req_table_value  (req_table_value),
      .dn_valid         (step_valid),
      .dn_stall         (step_stall),
      .dn_kind          (step_kind),
      .dn_addr          (step_addr),
      .dn_value         (step_value),
      .dn_inc           (step_inc)
   );

   // Stage 3: table writes land here, so a later sample transaction always
   // reads what an earlier write stored. Write transactions end here.
   wtosc_table #(
      .TABLE_BITS (TABLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .up_valid (step_valid),
      .up_stall (step_stall),
      .up_kind  (step_kind),
      .up_addr  (step_addr),
      .up_value (step_value),
      .up_inc   (step_inc),
      .dn_valid (tap_valid),
      .dn_stall (tap_stall),
      .dn_a     (tap_a),
      .dn_b     (tap_b),
      .dn_frac  (tap_frac)
   );

   // Stages 4 and 5: interpolation with round-to-nearest, ties upward.
   wtosc_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (tap_valid),
      .up_stall   (tap_stall),
      .up_a       (tap_a),
      .up_b       (tap_b),
      .up_frac    (tap_frac),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample)
   );

endmodule

`default_nettype wire

### sim/wavetable_oscillator_lerp_core_tb.sv
`timescale 1ns / 1ps

module wavetable_oscillator_lerp_core_tb;
   import wtosc_pkg::*;

   // Geometry of the block under test, taken from the package defaults.
   localparam int TBL_BITS  = TABLE_BITS_DEFAULT;
   localparam int FRC_BITS  = FRAC_BITS_DEFAULT;
   localparam int PHASE_W   = TBL_BITS + FRC_BITS;
   localparam int TBL_LEN   = 1 << TBL_BITS;
   localparam int INC_SHIFT = PROD_FRAC_BITS - FRC_BITS;

   // A table write retires at the table stage, behind the input and increment
   // registers, and SETTLE_CYCLES leaves room for it to get there.
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_PRINTED    = 200;

   localparam logic [SCALE_W-1:0] SCALE_UNITY = 32'h0100_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       csr_write_enable = 1'b0;
   logic [SCALE_W-1:0]         csr_write_data   = '0;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic                       req_kind         = KIND_SAMPLE;
   logic signed [FREQ_W-1:0]   req_freq         = '0;
   logic [ADDR_W-1:0]          req_table_addr   = '0;
   logic signed [SAMPLE_W-1:0] req_table_value  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;

   // Oscillator state as the checker sees it: phase, wave table and scale.
   logic [PHASE_W-1:0]         osc_phase;
   logic signed [SAMPLE_W-1:0] osc_table [TBL_LEN];
   logic [SCALE_W-1:0]         osc_step_scale;

   // Samples that the block still owes us, oldest first.
   logic signed [SAMPLE_W-1:0] expected_samples [$];

   int error_count    = 0;
   int tx_gap_pct     = 0;
   int rx_stall_pct   = 0;
   int rx_hold_cycles = 0;
   int quiet_cycles   = 0;

   always #5 clock = ~clock;

   wavetable_oscillator_lerp_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_freq         (req_freq),
      .req_table_addr   (req_table_addr),
      .req_table_value  (req_table_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample)
   );

   // Every mismatch goes through here. Printing stops after a while so a badly
   // broken block cannot flood the log, but every failure is still counted.
   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // Advance the oscillator state for one accepted transaction. A table write
   // only updates the table; a sample transaction interpolates between the
   // entry under the phase and its successor (wrapping at the table end), then
   // moves the phase by the frequency times the scale, wrapping the phase too.
   task automatic advance_oscillator(input kind_type kind,
                                     input logic signed [FREQ_W-1:0] freq,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic signed [SAMPLE_W-1:0] value);
      logic [TBL_BITS-1:0] idx;
      logic [TBL_BITS-1:0] nxt;
      longint              a;
      longint              b;
      longint              frac;
      longint              acc;
      longint              prod;
      longint              inc;
      if (kind == KIND_WRITE) begin
         osc_table[addr[TBL_BITS-1:0]] = value;
      end else begin
         idx  = osc_phase[PHASE_W-1:FRC_BITS];
         nxt  = idx + 1'b1;
         a    = longint'(osc_table[idx]);
         b    = longint'(osc_table[nxt]);
         frac = longint'(osc_phase[FRC_BITS-1:0]);
         // Round to nearest, ties upward: add half an LSB, then floor.
         acc  = (a <<< FRC_BITS) + (b - a) * frac + (longint'(1) <<< (FRC_BITS - 1));
         acc  = acc >>> FRC_BITS;
         expected_samples.push_back(acc[SAMPLE_W-1:0]);
         // The product is exact in 64 bits; the arithmetic shift floors it.
         prod = longint'(freq) * longint'(osc_step_scale);
         inc  = prod >>> INC_SHIFT;
         osc_phase = osc_phase + inc[PHASE_W-1:0];
      end
   endtask

   // Offer one transaction and hold it until the block takes it. A random gap
   // may come first, depending on how often the sender is meant to idle.
   // Valid is only ever assigned once per edge, so a back-to-back stream keeps
   // it high without a glitch.
   task automatic send_item(input kind_type kind,
                            input logic signed [FREQ_W-1:0] freq,
                            input logic [ADDR_W-1:0] addr,
                            input logic signed [SAMPLE_W-1:0] value);
      while ($urandom_range(0, 99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_freq        <= freq;
      req_table_addr  <= addr;
      req_table_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_oscillator(kind, freq, addr, value);
   endtask

   task automatic send_sample(input logic signed [FREQ_W-1:0] freq);
      send_item(KIND_SAMPLE, freq, ADDR_W'($urandom_range(0, TBL_LEN - 1)),
                SAMPLE_W'($urandom));
   endtask

   task automatic send_write(input logic [ADDR_W-1:0] addr,
                             input logic signed [SAMPLE_W-1:0] value);
      send_item(KIND_WRITE, $urandom, addr, value);
   endtask

   // Drop valid and wait until every owed sample has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   // The scale may only change while the pipeline is empty. Table writes give
   // no result, so after the last sample we still let the pipeline settle.
   task automatic write_step_scale(input logic [SCALE_W-1:0] scale);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= scale;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      osc_step_scale = scale;
   endtask

   // Mostly audio-rate frequencies of either sign, sometimes any 32-bit value,
   // sometimes the extremes of the field.
   function automatic logic signed [FREQ_W-1:0] random_freq();
      logic signed [FREQ_W-1:0] f;
      case ($urandom_range(0, 9))
         0: f = $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: f = 32'sh7FFF_FFFF;
               1: f = 32'sh8000_0000;
               2: f = 32'sd0;
               default: f = -32'sd1;
            endcase
         end
         default: begin
            f = $urandom_range(0, 32'd2621440000);
            if ($urandom_range(0, 4) == 0) f = -f;
         end
      endcase
      return f;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_value();
      logic signed [SAMPLE_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 16'sh7FFF;
         1: v = 16'sh8000;
         default: v = SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   // Fill the whole table first, so no sample can ever read an entry that has
   // never been written. The phase stays at zero during the fill.
   task automatic test_table_fill();
      for (int i = 0; i < TBL_LEN; i++) begin
         send_write(ADDR_W'(i), SAMPLE_W'($urandom));
      end
   endtask

   // Hand-placed cases. With a scale of exactly one the frequency word is the
   // phase increment itself, which makes it easy to park the phase anywhere.
   task automatic test_directed();
      logic signed [FREQ_W-1:0] to_target;
      // One sample at the reset value of the scale: 440 Hz.
      send_sample(32'sd440 <<< 16);
      write_step_scale(SCALE_UNITY);
      send_write(ADDR_W'(0), 16'sh8000);
      send_write(ADDR_W'(1), 16'sh7FFF);
      send_write(ADDR_W'(TBL_LEN - 1), 16'sh7FFF);
      // Bring the phase back to zero, then step through half and almost one
      // entry so the fraction sweeps across the full swing of the table.
      send_sample(-$signed(32'(osc_phase)));
      send_sample(32'sh0000_8000);
      send_sample(32'sd0);
      send_sample(32'sh0000_7FFF);
      send_sample(32'sd1);
      // Park halfway past the last entry; the next read wraps to entry zero.
      to_target = 32'((TBL_LEN - 1) << FRC_BITS) + 32'sh0000_8000 - 32'(osc_phase);
      send_sample(to_target);
      send_sample(32'sd0);
      // Increments far beyond the table length wrap like any other step.
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh8000_0000);
      send_write(ADDR_W'(TBL_LEN - 1), 16'sh8000);
      // A zero scale freezes the phase whatever the frequency.
      write_step_scale('0);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sd0);
      // The largest scale against the frequency extremes.
      write_step_scale('1);
      send_sample(32'sh8000_0000);
      send_sample(32'sh7FFF_FFFF);
      send_sample(-32'sd1);
   endtask

   // A stream of random transactions: about one in four is a table write.
   task automatic run_random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_write(ADDR_W'($urandom_range(0, TBL_LEN - 1)), random_value());
         end else begin
            send_sample(random_freq());
         end
      end
   endtask

   task automatic test_random_phase(input int tx_pct, input int rx_pct,
                                    input logic [SCALE_W-1:0] scale, input int count);
      write_step_scale(scale);
      tx_gap_pct   = tx_pct;
      rx_stall_pct = rx_pct;
      run_random_items(count);
   endtask

   // The receiver holds off for a long stretch while the sender keeps going,
   // so the pipeline fills up and the block has to stall its input.
   task automatic test_output_backpressure();
      tx_gap_pct     = 0;
      rx_stall_pct   = 0;
      rx_hold_cycles = 80;
      for (int i = 0; i < 80; i++) begin
         send_sample(random_freq());
      end
   endtask

   // The sender stops until every owed sample is back, then resumes; the
   // phase must carry over the pause unchanged.
   task automatic test_pause_and_resume();
      tx_gap_pct   = 0;
      rx_stall_pct = 24;
      run_random_items(40);
      wait_drained();
      run_random_items(40);
   endtask

   // Receiver side: random stalls, or a solid hold when a test asks for one.
   // The hold counter is only ever decremented here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_hold_cycles > 0) begin
         rsp_stall      <= 1'b1;
         rx_hold_cycles <= rx_hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
   end

   // Every accepted result is compared with the oldest owed sample.
   always @(posedge clock) begin : check_samples
      logic signed [SAMPLE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d with no transaction outstanding",
                                      rsp_sample));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want) begin
               report_mismatch($sformatf("sample got %0d, expected %0d",
                                         rsp_sample, want));
            end
         end
      end
   end

   // Ends the run when neither channel nor the register port moves for too long.
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && !req_stall) ||
          (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("wavetable_oscillator_lerp_core_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      osc_phase      = '0;
      osc_step_scale = STEP_SCALE_RESET;
      foreach (osc_table[i]) osc_table[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First the sender idles now and then and the receiver often.
      tx_gap_pct   = 24;
      rx_stall_pct = 66;
      test_table_fill();
      test_directed();
      test_random_phase(24, 66, STEP_SCALE_RESET, 150);
      // Then the roles swap, and finally nobody idles.
      test_random_phase(66, 24, $urandom, 150);
      test_random_phase(0, 0, '1, 150);
      test_output_backpressure();
      test_pause_and_resume();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0) begin
         report_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
      end
      if (error_count == 0) begin
         $display("wavetable_oscillator_lerp_core_tb OK");
      end else begin
         $display("wavetable_oscillator_lerp_core_tb NOT OK");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/wtosc_pkg.sv
src/wtosc_step.sv
src/wtosc_table.sv
src/wtosc_lerp.sv
src/wavetable_oscillator_lerp_core.sv
sim/wavetable_oscillator_lerp_core_tb.sv
